>>> rtl/tlpm_pkg.sv
// shared types and constants for the three-level page table mapper
`timescale 1ns / 1ps
`default_nettype none

package tlpm_pkg;

    // index split of a virtual page number, 4k pages
    localparam int unsigned TOP_BITS  = 7;
    localparam int unsigned MID_BITS  = 7;
    localparam int unsigned LEAF_BITS = 6;
    localparam int unsigned PAGE_BITS = 12;

    localparam logic [31:0] INVALID_DESC = 32'hDEAD0000;

    // descriptor bit positions
    localparam int unsigned DESC_WP_BIT     = 2;
    localparam int unsigned DESC_CM_LSB     = 5;
    localparam int unsigned DESC_CI_BIT     = 6;
    localparam int unsigned DESC_SUPER_BIT  = 7;
    localparam int unsigned DESC_GLOBAL_BIT = 10;

    // cache modes
    localparam logic [1:0] CM_WRITETHROUGH   = 2'd0;
    localparam logic [1:0] CM_COPYBACK       = 2'd1;
    localparam logic [1:0] CM_INHIBIT_SERIAL = 2'd2;
    localparam logic [1:0] CM_NONSERIALIZED  = 2'd3;

    // mmu kinds
    localparam logic [1:0] MMU_NONE = 2'd0;
    localparam logic [1:0] MMU_030  = 2'd1;
    localparam logic [1:0] MMU_040  = 2'd2;
    localparam logic [1:0] MMU_060  = 2'd3;

    // operations
    localparam logic OP_MAP    = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_MMU    = 2'd1;
    localparam logic [1:0] STATUS_EXHAUSTED = 2'd2;

    typedef struct packed {
        logic        op;
        logic [19:0] virt_page;
        logic [19:0] phys_page;
        logic        make_invalid;
        logic        write_protect;
        logic        supervisor_only;
        logic [1:0]  cache_mode;
        logic        single_page_region;
    } t_item;

    typedef struct packed {
        logic [31:0] descriptor;
        logic [1:0]  status;
    } t_result;

    typedef struct packed {
        logic top_we;
        logic mid_we;
        logic leaf_we;
    } t_store_we;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TOP,
        ST_MID,
        ST_LEAF
    } t_state;

endpackage

`default_nettype wire

>>> rtl/tlpm_alloc.sv
// shared pool allocation unit: exhaustion compare and link increment
`timescale 1ns / 1ps
`default_nettype none

module tlpm_alloc #(
    parameter int unsigned CNT_W = 7
) (
    input  wire logic [CNT_W-1:0] i_count,
    input  wire logic [CNT_W-1:0] i_limit,
    output logic                  o_full,
    output logic [CNT_W-1:0]      o_next
);

    assign o_full = (i_count >= i_limit);
    // link of a new table is its number plus one
    assign o_next = i_count + 1'b1;

endmodule

`default_nettype wire

>>> rtl/tlpm_desc.sv
// page descriptor builder for 68030 and 68040/060 formats
`timescale 1ns / 1ps
`default_nettype none

module tlpm_desc (
    input  wire logic [1:0]     i_mmu_kind,
    input  wire tlpm_pkg::t_item i_item,
    input  wire logic [31:0]    i_old,
    output logic [31:0]         o_desc
);

    logic       zero_single;
    logic       keep;
    logic [1:0] old_cm;

    assign zero_single = (i_item.virt_page == '0) && i_item.single_page_region;
    assign keep        = (i_old[1:0] != 2'b00);
    assign old_cm      = i_old[tlpm_pkg::DESC_CM_LSB +: 2];

    always_comb begin
        o_desc = {i_item.phys_page, {tlpm_pkg::PAGE_BITS{1'b0}}};
        if (i_item.make_invalid) begin
            if (zero_single) begin
                // zero page becomes a protected serialised page
                o_desc[tlpm_pkg::DESC_WP_BIT]            = 1'b1;
                o_desc[tlpm_pkg::DESC_CM_LSB +: 2]       = tlpm_pkg::CM_INHIBIT_SERIAL;
            end else begin
                o_desc = tlpm_pkg::INVALID_DESC;
            end
        end else if (i_mmu_kind == tlpm_pkg::MMU_030) begin
            o_desc[0] = 1'b1;
            o_desc[tlpm_pkg::DESC_WP_BIT] = i_item.write_protect
                || (keep && i_old[tlpm_pkg::DESC_WP_BIT]);
            o_desc[tlpm_pkg::DESC_CI_BIT] = (i_item.cache_mode >= tlpm_pkg::CM_INHIBIT_SERIAL)
                || (keep && i_old[tlpm_pkg::DESC_CI_BIT]);
        end else begin
            o_desc[1:0] = 2'b11;
            o_desc[tlpm_pkg::DESC_WP_BIT] = i_item.write_protect
                || (keep && i_old[tlpm_pkg::DESC_WP_BIT]);
            o_desc[tlpm_pkg::DESC_SUPER_BIT] = i_item.supervisor_only
                || (keep && i_old[tlpm_pkg::DESC_SUPER_BIT]);
            // keep the less cached mode
            o_desc[tlpm_pkg::DESC_CM_LSB +: 2] = (!keep || (i_item.cache_mode > old_cm))
                ? i_item.cache_mode : old_cm;
            o_desc[tlpm_pkg::DESC_GLOBAL_BIT] = !zero_single;
        end
    end

endmodule

`default_nettype wire

>>> rtl/tlpm_store.sv
// top, middle and leaf table stores with the clearing pass after reset
`timescale 1ns / 1ps
`default_nettype none

module tlpm_store #(
    parameter int unsigned MID_POOL_TABLES  = 16,
    parameter int unsigned LEAF_POOL_TABLES = 64,
    localparam int unsigned TL_W = $clog2(MID_POOL_TABLES + 1),
    localparam int unsigned ML_W = $clog2(LEAF_POOL_TABLES + 1),
    localparam int unsigned MID_IDX_W  = (MID_POOL_TABLES > 1)
                                         ? $clog2(MID_POOL_TABLES) : 1,
    localparam int unsigned LEAF_IDX_W = (LEAF_POOL_TABLES > 1)
                                         ? $clog2(LEAF_POOL_TABLES) : 1,
    localparam int unsigned MID_AW  = MID_IDX_W + tlpm_pkg::MID_BITS,
    localparam int unsigned LEAF_AW = LEAF_IDX_W + tlpm_pkg::LEAF_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire tlpm_pkg::t_store_we   i_we,
    input  wire logic [tlpm_pkg::TOP_BITS-1:0] i_top_raddr,
    input  wire logic [tlpm_pkg::TOP_BITS-1:0] i_top_waddr,
    input  wire logic [TL_W-1:0]       i_top_wdata,
    input  wire logic [MID_AW-1:0]     i_mid_raddr,
    input  wire logic [MID_AW-1:0]     i_mid_waddr,
    input  wire logic [ML_W-1:0]       i_mid_wdata,
    input  wire logic [LEAF_AW-1:0]    i_leaf_raddr,
    input  wire logic [LEAF_AW-1:0]    i_leaf_waddr,
    input  wire logic [31:0]           i_leaf_wdata,
    output logic [TL_W-1:0]            o_top_q,
    output logic [ML_W-1:0]            o_mid_q,
    output logic [31:0]                o_leaf_q,
    output logic                       o_clr_busy
);

    localparam int unsigned TOP_DEPTH  = 1 << tlpm_pkg::TOP_BITS;
    localparam int unsigned MID_DEPTH  = MID_POOL_TABLES * (1 << tlpm_pkg::MID_BITS);
    localparam int unsigned LEAF_DEPTH = LEAF_POOL_TABLES * (1 << tlpm_pkg::LEAF_BITS);
    localparam int unsigned CLR_W      = (MID_AW > LEAF_AW) ? MID_AW : LEAF_AW;
    localparam int unsigned CLR_LAST   = ((MID_DEPTH > LEAF_DEPTH) ? MID_DEPTH : LEAF_DEPTH) - 1;

    logic [TL_W-1:0]  top_mem  [TOP_DEPTH];
    logic [ML_W-1:0]  mid_mem  [MID_DEPTH];
    logic [31:0]      leaf_mem [LEAF_DEPTH];

    logic [CLR_W-1:0] r_clr_cnt;
    logic             r_clr_busy;
    logic             clr_top;
    logic             clr_mid;
    logic             clr_leaf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt  <= '0;
            r_clr_busy <= 1'b1;
        end else if (r_clr_busy) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == CLR_W'(CLR_LAST)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    assign clr_top  = r_clr_busy && ({1'b0, r_clr_cnt} < (CLR_W + 1)'(TOP_DEPTH));
    assign clr_mid  = r_clr_busy && ({1'b0, r_clr_cnt} < (CLR_W + 1)'(MID_DEPTH));
    assign clr_leaf = r_clr_busy && ({1'b0, r_clr_cnt} < (CLR_W + 1)'(LEAF_DEPTH));
    assign o_clr_busy = r_clr_busy;

    always_ff @(posedge i_clk) begin
        if (clr_top) begin
            top_mem[r_clr_cnt[tlpm_pkg::TOP_BITS-1:0]] <= '0;
        end else if (!r_clr_busy && i_we.top_we) begin
            top_mem[i_top_waddr] <= i_top_wdata;
        end
        o_top_q <= top_mem[i_top_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (clr_mid) begin
            mid_mem[r_clr_cnt[MID_AW-1:0]] <= '0;
        end else if (!r_clr_busy && i_we.mid_we) begin
            mid_mem[i_mid_waddr] <= i_mid_wdata;
        end
        o_mid_q <= mid_mem[i_mid_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (clr_leaf) begin
            leaf_mem[r_clr_cnt[LEAF_AW-1:0]] <= tlpm_pkg::INVALID_DESC;
        end else if (!r_clr_busy && i_we.leaf_we) begin
            leaf_mem[i_leaf_waddr] <= i_leaf_wdata;
        end
        o_leaf_q <= leaf_mem[i_leaf_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/three_level_page_table_mapper_top.sv
// top level of the three-level page table mapper: sequencer, registers, result port
`timescale 1ns / 1ps
`default_nettype none

// three-level page table mapper. an item is taken when start is high and busy
// is low; its result (descriptor and status) appears on o_result for exactly
// one cycle with o_strobe high and cannot be held off by the receiver. a map or
// lookup walks the top, middle and leaf stores one registered read per cycle,
// and the next item may already be taken while the last result is on o_result;
// a lookup of an unmapped page, or a map that finds a pool exhausted, ends
// early at the top or middle step, and with no mmu configured the result
// follows in the next cycle. middle and leaf tables are handed out in order
// from fixed pools and never returned. after reset a clearing pass over the
// larger of the middle and leaf stores holds busy high; the mmu kind register
// is always ready and should only be written while no item is in flight
module three_level_page_table_mapper_top #(
    parameter int unsigned MID_POOL_TABLES  = 16,
    parameter int unsigned LEAF_POOL_TABLES = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire tlpm_pkg::t_item   i_item,
    output logic                   o_strobe,
    output tlpm_pkg::t_result      o_result,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [1:0]        i_cfg_data
);

    // link widths hold table number plus one, zero meaning invalid
    localparam int unsigned TL_W = $clog2(MID_POOL_TABLES + 1);
    localparam int unsigned ML_W = $clog2(LEAF_POOL_TABLES + 1);
    localparam int unsigned MID_IDX_W  = (MID_POOL_TABLES > 1)
                                         ? $clog2(MID_POOL_TABLES) : 1;
    localparam int unsigned LEAF_IDX_W = (LEAF_POOL_TABLES > 1)
                                         ? $clog2(LEAF_POOL_TABLES) : 1;
    localparam int unsigned MID_AW  = MID_IDX_W + tlpm_pkg::MID_BITS;
    localparam int unsigned LEAF_AW = LEAF_IDX_W + tlpm_pkg::LEAF_BITS;
    localparam int unsigned CNT_W   = (TL_W > ML_W) ? TL_W : ML_W;

    // sequencer and item registers
    tlpm_pkg::t_state   r_state, n_state;
    tlpm_pkg::t_item    r_item;
    tlpm_pkg::t_result  r_result, n_result;
    logic               r_strobe, n_strobe;
    logic [1:0]         r_mmu_kind;
    logic [TL_W-1:0]    r_mid_used, n_mid_used;
    logic [ML_W-1:0]    r_leaf_used, n_leaf_used;
    logic [MID_IDX_W-1:0]  r_mid_idx, n_mid_idx;
    logic [LEAF_IDX_W-1:0] r_leaf_idx, n_leaf_idx;

    // store side
    tlpm_pkg::t_store_we store_we;
    logic [TL_W-1:0]    top_q;
    logic [ML_W-1:0]    mid_q;
    logic [31:0]        leaf_q;
    logic               clr_busy;
    logic [MID_AW-1:0]  mid_raddr, mid_waddr;
    logic [LEAF_AW-1:0] leaf_raddr, leaf_waddr;
    logic [tlpm_pkg::TOP_BITS-1:0]  in_top_idx, item_top_idx;
    logic [tlpm_pkg::MID_BITS-1:0]  item_mid_idx;
    logic [tlpm_pkg::LEAF_BITS-1:0] item_leaf_idx;

    // shared allocation unit
    logic [CNT_W-1:0]   alloc_count, alloc_limit, alloc_next;
    logic               alloc_full;

    logic [31:0]        new_desc;
    logic               accept;
    logic               is_lookup;
    logic               top_hit;
    logic               mid_hit;

    assign accept      = start && !busy;
    assign busy        = clr_busy || (r_state != tlpm_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = r_strobe;
    assign o_result    = r_result;

    // virtual page split: top, middle, leaf index
    assign in_top_idx    = i_item.virt_page[tlpm_pkg::LEAF_BITS + tlpm_pkg::MID_BITS
                                            +: tlpm_pkg::TOP_BITS];
    assign item_top_idx  = r_item.virt_page[tlpm_pkg::LEAF_BITS + tlpm_pkg::MID_BITS
                                            +: tlpm_pkg::TOP_BITS];
    assign item_mid_idx  = r_item.virt_page[tlpm_pkg::LEAF_BITS +: tlpm_pkg::MID_BITS];
    assign item_leaf_idx = r_item.virt_page[tlpm_pkg::LEAF_BITS-1:0];

    assign is_lookup = (r_item.op == tlpm_pkg::OP_LOOKUP);
    assign top_hit   = (top_q != '0);
    assign mid_hit   = (mid_q != '0);

    // next read addresses follow the table chosen this cycle
    assign mid_raddr  = {n_mid_idx, item_mid_idx};
    assign mid_waddr  = {r_mid_idx, item_mid_idx};
    assign leaf_raddr = {n_leaf_idx, item_leaf_idx};
    assign leaf_waddr = {r_leaf_idx, item_leaf_idx};

    tlpm_alloc #(
        .CNT_W (CNT_W)
    ) u_alloc (
        .i_count (alloc_count),
        .i_limit (alloc_limit),
        .o_full  (alloc_full),
        .o_next  (alloc_next)
    );

    tlpm_desc u_desc (
        .i_mmu_kind (r_mmu_kind),
        .i_item     (r_item),
        .i_old      (leaf_q),
        .o_desc     (new_desc)
    );

    tlpm_store #(
        .MID_POOL_TABLES  (MID_POOL_TABLES),
        .LEAF_POOL_TABLES (LEAF_POOL_TABLES)
    ) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_we         (store_we),
        .i_top_raddr  (in_top_idx),
        .i_top_waddr  (item_top_idx),
        .i_top_wdata  (TL_W'(alloc_next)),
        .i_mid_raddr  (mid_raddr),
        .i_mid_waddr  (mid_waddr),
        .i_mid_wdata  (ML_W'(alloc_next)),
        .i_leaf_raddr (leaf_raddr),
        .i_leaf_waddr (leaf_waddr),
        .i_leaf_wdata (new_desc),
        .o_top_q      (top_q),
        .o_mid_q      (mid_q),
        .o_leaf_q     (leaf_q),
        .o_clr_busy   (clr_busy)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tlpm_pkg::ST_IDLE: begin
                if (accept && (r_mmu_kind != tlpm_pkg::MMU_NONE)) begin
                    n_state = tlpm_pkg::ST_TOP;
                end
            end
            tlpm_pkg::ST_TOP: begin
                // go on when a middle table exists or one can be taken
                if (top_hit || (!is_lookup && !alloc_full)) begin
                    n_state = tlpm_pkg::ST_MID;
                end else begin
                    n_state = tlpm_pkg::ST_IDLE;
                end
            end
            tlpm_pkg::ST_MID: begin
                if (mid_hit || (!is_lookup && !alloc_full)) begin
                    n_state = tlpm_pkg::ST_LEAF;
                end else begin
                    n_state = tlpm_pkg::ST_IDLE;
                end
            end
            tlpm_pkg::ST_LEAF: begin
                n_state = tlpm_pkg::ST_IDLE;
            end
            default: begin
                n_state = tlpm_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of each step
    always_comb begin
        n_result    = '0;
        n_strobe    = 1'b0;
        store_we    = '0;
        n_mid_used  = r_mid_used;
        n_leaf_used = r_leaf_used;
        n_mid_idx   = r_mid_idx;
        n_leaf_idx  = r_leaf_idx;
        alloc_count = CNT_W'(r_mid_used);
        alloc_limit = CNT_W'(MID_POOL_TABLES);
        case (r_state)
            tlpm_pkg::ST_IDLE: begin
                // with no mmu every item answers at once and changes nothing
                if (accept && (r_mmu_kind == tlpm_pkg::MMU_NONE)) begin
                    n_strobe        = 1'b1;
                    n_result.status = tlpm_pkg::STATUS_NO_MMU;
                end
            end
            tlpm_pkg::ST_TOP: begin
                if (top_hit) begin
                    n_mid_idx = MID_IDX_W'(top_q - 1'b1);
                end else if (is_lookup) begin
                    n_strobe            = 1'b1;
                    n_result.descriptor = tlpm_pkg::INVALID_DESC;
                end else if (alloc_full) begin
                    n_strobe        = 1'b1;
                    n_result.status = tlpm_pkg::STATUS_EXHAUSTED;
                end else begin
                    // take the next middle table, already cleared
                    store_we.top_we = 1'b1;
                    n_mid_used      = TL_W'(alloc_next);
                    n_mid_idx       = MID_IDX_W'(r_mid_used);
                end
            end
            tlpm_pkg::ST_MID: begin
                alloc_count = CNT_W'(r_leaf_used);
                alloc_limit = CNT_W'(LEAF_POOL_TABLES);
                if (mid_hit) begin
                    n_leaf_idx = LEAF_IDX_W'(mid_q - 1'b1);
                end else if (is_lookup) begin
                    n_strobe            = 1'b1;
                    n_result.descriptor = tlpm_pkg::INVALID_DESC;
                end else if (alloc_full) begin
                    n_strobe        = 1'b1;
                    n_result.status = tlpm_pkg::STATUS_EXHAUSTED;
                end else begin
                    // take the next leaf table, already filled with invalid marks
                    store_we.mid_we = 1'b1;
                    n_leaf_used     = ML_W'(alloc_next);
                    n_leaf_idx      = LEAF_IDX_W'(r_leaf_used);
                end
            end
            tlpm_pkg::ST_LEAF: begin
                n_strobe = 1'b1;
                if (is_lookup) begin
                    n_result.descriptor = leaf_q;
                end else begin
                    store_we.leaf_we    = 1'b1;
                    n_result.descriptor = new_desc;
                end
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tlpm_pkg::ST_IDLE;
            r_strobe    <= 1'b0;
            r_mmu_kind  <= tlpm_pkg::MMU_NONE;
            r_mid_used  <= '0;
            r_leaf_used <= '0;
        end else begin
            r_state     <= n_state;
            r_strobe    <= n_strobe;
            r_mid_used  <= n_mid_used;
            r_leaf_used <= n_leaf_used;
            if (i_cfg_valid && o_cfg_ready) begin
                r_mmu_kind <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
        r_result   <= n_result;
        r_mid_idx  <= n_mid_idx;
        r_leaf_idx <= n_leaf_idx;
    end

    // a result only follows an accept or a walk step
    a_strobe_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept || (r_state != tlpm_pkg::ST_IDLE)))
        else $error("result strobe without an item in flight");

    // pools are never overdrawn
    a_pool_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mid_used <= TL_W'(MID_POOL_TABLES)) && (r_leaf_used <= ML_W'(LEAF_POOL_TABLES)))
        else $error("table pool count beyond its size");

    // tables are never handed back
    a_pool_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_mid_used >= $past(r_mid_used)) && (r_leaf_used >= $past(r_leaf_used)))
        else $error("table pool count went down");

    // exhaustion is reported only from a table step
    a_exhaust_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.status == tlpm_pkg::STATUS_EXHAUSTED))
        |-> $past((r_state == tlpm_pkg::ST_TOP) || (r_state == tlpm_pkg::ST_MID)))
        else $error("exhausted status outside a table step");

endmodule

`default_nettype wire
